FILE: hdl/mtenpc_pkg.sv
// Shared types and instruction codes for the trap emulation and next-PC block.
package mtenpc_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_COP0    = 6'd16;
   localparam logic [5:0] OP_BNEL    = 6'd21;
   localparam logic [5:0] OP_DADDIU  = 6'd25;
   localparam logic [5:0] OP_LDL     = 6'd26;
   localparam logic [5:0] OP_LDR     = 6'd27;
   localparam logic [5:0] OP_SDL     = 6'd44;
   localparam logic [5:0] OP_SDR     = 6'd45;
   localparam logic [5:0] OP_CACHE   = 6'd47;
   localparam logic [5:0] OP_LLD     = 6'd52;
   localparam logic [5:0] OP_LD      = 6'd55;
   localparam logic [5:0] OP_SCD     = 6'd60;
   localparam logic [5:0] OP_SD      = 6'd63;

   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_JALR    = 6'd9;
   localparam logic [5:0] FN_DADDU   = 6'd45;
   localparam logic [5:0] FN_DSLL32  = 6'd60;
   localparam logic [5:0] FN_DSRL32  = 6'd62;
   localparam logic [5:0] FN_DSRA32  = 6'd63;

   localparam logic [4:0]  LINK_REG  = 5'd31;
   localparam logic [63:0] PC_STEP   = 64'd4;
   localparam logic [63:0] LINK_STEP = 64'd8;

   typedef enum logic [1:0] {
      ST_DONE        = 2'd0,
      ST_UNIMPL      = 2'd1,
      ST_NOT_HANDLED = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] trapped_word;
      logic [31:0] branch_word;
      logic [63:0] trap_pc;
      logic        in_delay_slot;
      logic [63:0] op_rs_value;
      logic [63:0] op_rt_value;
      logic [63:0] branch_rs_value;
      logic [63:0] branch_rt_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        dest_write;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
   } exec_type;

   typedef struct packed {
      logic        dest_write;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      logic        link_write;
      logic [4:0]  link_index;
      logic [63:0] link_value;
      logic [63:0] next_pc;
      status_type  status;
   } rsp_type;

endpackage

FILE: hdl/mips_trap_emulate_next_pc.sv
// Top level: input register, emulation and next-PC logic, result register.
//
//   Channel | Direction | Handshake            | Carries
//   req_    | in        | req_valid/req_ready  | trapped and branch words, PC, values
//   rsp_    | out       | rsp_valid/rsp_ready  | dest and link writes, next PC, status
//
// One request is taken every cycle unless the input register is full and the result register is blocked.
// The input register feeds one pass of adder, shifter and compare logic into
// the result register. Reset clears both valid bits only.
// While the result waits, the input register still takes one more request.
module mips_trap_emulate_next_pc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_trapped_word,
   input  logic [31:0] req_branch_word,
   input  logic [63:0] req_trap_pc,
   input  logic        req_in_delay_slot,
   input  logic [63:0] req_op_rs_value,
   input  logic [63:0] req_op_rt_value,
   input  logic [63:0] req_branch_rs_value,
   input  logic [63:0] req_branch_rt_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_dest_write,
   output logic [4:0]  rsp_dest_index,
   output logic [63:0] rsp_dest_value,
   output logic        rsp_link_write,
   output logic [4:0]  rsp_link_index,
   output logic [63:0] rsp_link_value,
   output logic [63:0] rsp_next_pc,
   output logic [1:0]  rsp_status
);
   import mtenpc_pkg::*;

   req_type  s1_req_ff;
   req_type  s1_req_in;
   logic     s1_valid_ff;
   logic     s1_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   exec_type exec;
   logic     rsp_free;
   logic     s1_move;
   logic     req_take;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_take  = req_valid && req_ready;

   assign s1_req_in.trapped_word    = req_trapped_word;
   assign s1_req_in.branch_word     = req_branch_word;
   assign s1_req_in.trap_pc         = req_trap_pc;
   assign s1_req_in.in_delay_slot   = req_in_delay_slot;
   assign s1_req_in.op_rs_value     = req_op_rs_value;
   assign s1_req_in.op_rt_value     = req_op_rt_value;
   assign s1_req_in.branch_rs_value = req_branch_rs_value;
   assign s1_req_in.branch_rt_value = req_branch_rt_value;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   mtenpc_exec u_exec (
      .trapped_word (s1_req_ff.trapped_word),
      .op_rs_value  (s1_req_ff.op_rs_value),
      .op_rt_value  (s1_req_ff.op_rt_value),
      .exec         (exec)
   );

   mtenpc_next_pc u_next_pc (
      .exec            (exec),
      .branch_word     (s1_req_ff.branch_word),
      .trap_pc         (s1_req_ff.trap_pc),
      .in_delay_slot   (s1_req_ff.in_delay_slot),
      .branch_rs_value (s1_req_ff.branch_rs_value),
      .branch_rt_value (s1_req_ff.branch_rt_value),
      .rsp             (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= s1_req_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_write = rsp_ff.dest_write;
   assign rsp_dest_index = rsp_ff.dest_index;
   assign rsp_dest_value = rsp_ff.dest_value;
   assign rsp_link_write = rsp_ff.link_write;
   assign rsp_link_index = rsp_ff.link_index;
   assign rsp_link_value = rsp_ff.link_value;
   assign rsp_next_pc    = rsp_ff.next_pc;
   assign rsp_status     = rsp_ff.status;

`ifndef SYNTH
   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_free |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("Input register changed while the result register was blocked.");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("Request left the input register but no result appeared.");

   a_fail_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_DONE |-> !rsp_ff.dest_write && !rsp_ff.link_write)
      else $error("Failed request reports a register write.");

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.dest_write || rsp_ff.link_write) |->
         (!rsp_ff.dest_write || rsp_ff.dest_index != 5'd0) &&
         (!rsp_ff.link_write || rsp_ff.link_index != 5'd0))
      else $error("Write to register zero was reported.");
`endif

endmodule

FILE: hdl/mtenpc_exec.sv
// Emulation of the trapped instruction: 64-bit adds, the 32-plus shifts and the status codes.
module mtenpc_exec (
   input  logic [31:0]          trapped_word,
   input  logic [63:0]          op_rs_value,
   input  logic [63:0]          op_rt_value,
   output mtenpc_pkg::exec_type exec
);
   import mtenpc_pkg::*;

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [5:0]  shamt;
   logic [63:0] imm;

   assign op    = trapped_word[31:26];
   assign fn    = trapped_word[5:0];
   assign shamt = {1'b1, trapped_word[10:6]};
   assign imm   = {{48{trapped_word[15]}}, trapped_word[15:0]};

   always_comb begin
      exec.status     = ST_DONE;
      exec.dest_write = 1'b0;
      exec.dest_index = 5'd0;
      exec.dest_value = 64'd0;
      unique case (op)
         OP_SPECIAL: begin
            unique case (fn)
               FN_DADDU: begin
                  exec.dest_write = 1'b1;
                  exec.dest_index = trapped_word[15:11];
                  exec.dest_value = op_rs_value + op_rt_value;
               end
               FN_DSLL32: begin
                  exec.dest_write = 1'b1;
                  exec.dest_index = trapped_word[15:11];
                  exec.dest_value = op_rt_value << shamt;
               end
               FN_DSRL32: begin
                  exec.dest_write = 1'b1;
                  exec.dest_index = trapped_word[15:11];
                  exec.dest_value = op_rt_value >> shamt;
               end
               FN_DSRA32: begin
                  exec.dest_write = 1'b1;
                  exec.dest_index = trapped_word[15:11];
                  exec.dest_value = $unsigned($signed(op_rt_value) >>> shamt);
               end
               default: begin
                  exec.status = ST_UNIMPL;
               end
            endcase
         end
         OP_DADDIU: begin
            exec.dest_write = 1'b1;
            exec.dest_index = trapped_word[20:16];
            exec.dest_value = op_rs_value + imm;
         end
         OP_CACHE: begin
            exec.status = ST_DONE;
         end
         OP_COP0, OP_LD, OP_LDL, OP_LDR, OP_LLD, OP_SD, OP_SDL, OP_SDR, OP_SCD: begin
            exec.status = ST_NOT_HANDLED;
         end
         default: begin
            exec.status = ST_UNIMPL;
         end
      endcase
      // Writes to register zero are dropped and never forwarded.
      if (!exec.dest_write || exec.dest_index == 5'd0) begin
         exec.dest_write = 1'b0;
         exec.dest_index = 5'd0;
         exec.dest_value = 64'd0;
      end
   end

endmodule

FILE: hdl/mtenpc_next_pc.sv
// Branch resolution in the delay slot, link write and final result assembly.
module mtenpc_next_pc (
   input  mtenpc_pkg::exec_type exec,
   input  logic [31:0]          branch_word,
   input  logic [63:0]          trap_pc,
   input  logic                 in_delay_slot,
   input  logic [63:0]          branch_rs_value,
   input  logic [63:0]          branch_rt_value,
   output mtenpc_pkg::rsp_type  rsp
);
   import mtenpc_pkg::*;

   logic [5:0]  bop;
   logic [5:0]  bfn;
   logic [63:0] vs;
   logic [63:0] vt;
   logic [63:0] taken_pc;
   logic [63:0] jump_pc;
   logic [63:0] seq_pc;
   logic [63:0] link_pc;

   assign bop      = branch_word[31:26];
   assign bfn      = branch_word[5:0];
   assign vs       = (exec.dest_write && exec.dest_index == branch_word[25:21]) ?
                     exec.dest_value : branch_rs_value;
   assign vt       = (exec.dest_write && exec.dest_index == branch_word[20:16]) ?
                     exec.dest_value : branch_rt_value;
   assign taken_pc = trap_pc + {{46{branch_word[15]}}, branch_word[15:0], 2'b00} + PC_STEP;
   assign jump_pc  = {trap_pc[63:28], branch_word[25:0], 2'b00};
   assign seq_pc   = trap_pc + PC_STEP;
   assign link_pc  = trap_pc + LINK_STEP;

   always_comb begin
      rsp.dest_write = exec.dest_write;
      rsp.dest_index = exec.dest_index;
      rsp.dest_value = exec.dest_value;
      rsp.link_write = 1'b0;
      rsp.link_index = 5'd0;
      rsp.link_value = 64'd0;
      rsp.status     = exec.status;
      rsp.next_pc    = trap_pc;
      if (exec.status == ST_DONE && !in_delay_slot) begin
         rsp.next_pc = seq_pc;
      end else if (exec.status == ST_DONE) begin
         rsp.next_pc = link_pc;
         unique case (bop)
            OP_BEQ: begin
               if (vs == vt) rsp.next_pc = taken_pc;
            end
            OP_BNE, OP_BNEL: begin
               if (vs != vt) rsp.next_pc = taken_pc;
            end
            OP_BLEZ: begin
               if (vs[63] || vs == 64'd0) rsp.next_pc = taken_pc;
            end
            OP_BGTZ: begin
               if (!vs[63] && vs != 64'd0) rsp.next_pc = taken_pc;
            end
            OP_J: begin
               rsp.next_pc = jump_pc;
            end
            OP_JAL: begin
               rsp.next_pc    = jump_pc;
               rsp.link_write = 1'b1;
               rsp.link_index = LINK_REG;
               rsp.link_value = link_pc;
            end
            OP_SPECIAL: begin
               if (bfn == FN_JR) begin
                  rsp.next_pc = vs;
               end else if (bfn == FN_JALR) begin
                  rsp.next_pc    = vs;
                  rsp.link_write = 1'b1;
                  rsp.link_index = branch_word[15:11];
                  rsp.link_value = link_pc;
               end else begin
                  rsp.status = ST_UNIMPL;
               end
            end
            default: begin
               rsp.status = ST_UNIMPL;
            end
         endcase
         if (rsp.link_index == 5'd0) begin
            rsp.link_write = 1'b0;
            rsp.link_value = 64'd0;
         end
      end
      // A failed request writes nothing and resumes at the trap PC.
      if (rsp.status != ST_DONE) begin
         rsp.dest_write = 1'b0;
         rsp.dest_index = 5'd0;
         rsp.dest_value = 64'd0;
         rsp.link_write = 1'b0;
         rsp.link_index = 5'd0;
         rsp.link_value = 64'd0;
         rsp.next_pc    = trap_pc;
      end
   end

endmodule

FILE: tb/mips_trap_emulate_next_pc_test.sv
// Testbench for the trap emulation and next-PC block: directed table, random requests, predictor.
`timescale 1ns / 100ps

module mips_trap_emulate_next_pc_test;
   import mtenpc_pkg::*;

   localparam logic [5:0] OP_BCOND  = 6'd1;
   localparam logic [5:0] OP_UNUSED = 6'd8;
   localparam logic [5:0] FN_UNUSED = 6'd32;
   localparam logic [63:0] MAX_POS  = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] BASE_PC  = 64'h0000_0000_8000_1000;
   localparam int RANDOM_ITEMS = 1125;
   localparam int QUIET_TAIL   = 150;

   typedef struct {
      req_type req;
      bit      has_golden;
      rsp_type golden;
   } trap_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_trapped_word = '0;
   logic [31:0] req_branch_word = '0;
   logic [63:0] req_trap_pc = '0;
   logic        req_in_delay_slot = 1'b0;
   logic [63:0] req_op_rs_value = '0;
   logic [63:0] req_op_rt_value = '0;
   logic [63:0] req_branch_rs_value = '0;
   logic [63:0] req_branch_rt_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_dest_write;
   logic [4:0]  rsp_dest_index;
   logic [63:0] rsp_dest_value;
   logic        rsp_link_write;
   logic [4:0]  rsp_link_index;
   logic [63:0] rsp_link_value;
   logic [63:0] rsp_next_pc;
   logic [1:0]  rsp_status;

   bit            idle_enable = 1'b0;
   int            rsp_stall_left = 0;
   int            fail_count = 0;
   rsp_type       predicted_rsps[$];
   trap_case_type directed_cases[$];

   mips_trap_emulate_next_pc uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_trapped_word    (req_trapped_word),
      .req_branch_word     (req_branch_word),
      .req_trap_pc         (req_trap_pc),
      .req_in_delay_slot   (req_in_delay_slot),
      .req_op_rs_value     (req_op_rs_value),
      .req_op_rt_value     (req_op_rt_value),
      .req_branch_rs_value (req_branch_rs_value),
      .req_branch_rt_value (req_branch_rt_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dest_write      (rsp_dest_write),
      .rsp_dest_index      (rsp_dest_index),
      .rsp_dest_value      (rsp_dest_value),
      .rsp_link_write      (rsp_link_write),
      .rsp_link_index      (rsp_link_index),
      .rsp_link_value      (rsp_link_value),
      .rsp_next_pc         (rsp_next_pc),
      .rsp_status          (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [31:0] spec_word(input logic [4:0] rs, input logic [4:0] rt,
                                             input logic [4:0] rd, input logic [4:0] sa,
                                             input logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] imm_word(input logic [5:0] op, input logic [4:0] rs,
                                            input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic req_type make_req(input logic [31:0] tw, input logic [31:0] bw,
                                        input logic [63:0] pc, input logic slot,
                                        input logic [63:0] ors, input logic [63:0] ort,
                                        input logic [63:0] brs, input logic [63:0] brt);
      req_type r;
      r.trapped_word    = tw;
      r.branch_word     = bw;
      r.trap_pc         = pc;
      r.in_delay_slot   = slot;
      r.op_rs_value     = ors;
      r.op_rt_value     = ort;
      r.branch_rs_value = brs;
      r.branch_rt_value = brt;
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic dw, input logic [4:0] di,
                                        input logic [63:0] dv, input logic lw,
                                        input logic [4:0] li, input logic [63:0] lv,
                                        input logic [63:0] npc, input status_type st);
      rsp_type p;
      p.dest_write = dw;
      p.dest_index = di;
      p.dest_value = dv;
      p.link_write = lw;
      p.link_index = li;
      p.link_value = lv;
      p.next_pc    = npc;
      p.status     = st;
      return p;
   endfunction

   function automatic rsp_type predict_trap(input req_type r);
      logic [31:0] tw, bw;
      logic [5:0]  op, fn, bop, bfn;
      logic [4:0]  rt, rd, sa, bs, bt, bd, di, li;
      logic [63:0] pc, dv, lv, npc, vs, vt, taken, jt;
      logic        dw, lw;
      status_type  st;
      tw = r.trapped_word;
      bw = r.branch_word;
      pc = r.trap_pc;
      op = tw[31:26];
      fn = tw[5:0];
      rt = tw[20:16];
      rd = tw[15:11];
      sa = tw[10:6];
      st = ST_DONE;
      dw = 1'b0;
      lw = 1'b0;
      di = '0;
      li = '0;
      dv = '0;
      lv = '0;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_DADDU: begin
                  dw = 1'b1; di = rd; dv = r.op_rs_value + r.op_rt_value;
               end
               FN_DSLL32: begin
                  dw = 1'b1; di = rd; dv = r.op_rt_value << {1'b1, sa};
               end
               FN_DSRL32: begin
                  dw = 1'b1; di = rd; dv = r.op_rt_value >> {1'b1, sa};
               end
               FN_DSRA32: begin
                  dw = 1'b1; di = rd; dv = $signed(r.op_rt_value) >>> {1'b1, sa};
               end
               default: st = ST_UNIMPL;
            endcase
         end
         OP_DADDIU: begin
            dw = 1'b1; di = rt; dv = r.op_rs_value + {{48{tw[15]}}, tw[15:0]};
         end
         OP_CACHE: ;
         OP_COP0, OP_LD, OP_LDL, OP_LDR, OP_LLD, OP_SD, OP_SDL, OP_SDR, OP_SCD:
            st = ST_NOT_HANDLED;
         default: st = ST_UNIMPL;
      endcase
      if (dw && di == 5'd0) begin
         dw = 1'b0;
         dv = '0;
      end

      if (st == ST_DONE && !r.in_delay_slot) begin
         npc = pc + PC_STEP;
      end else if (st == ST_DONE) begin
         bop = bw[31:26];
         bfn = bw[5:0];
         bs  = bw[25:21];
         bt  = bw[20:16];
         bd  = bw[15:11];
         vs  = (dw && di == bs) ? dv : r.branch_rs_value;
         vt  = (dw && di == bt) ? dv : r.branch_rt_value;
         taken = pc + {{46{bw[15]}}, bw[15:0], 2'b00} + PC_STEP;
         jt  = {pc[63:28], bw[25:0], 2'b00};
         npc = pc + LINK_STEP;
         case (bop)
            OP_BEQ: if (vs == vt) npc = taken;
            OP_BNE, OP_BNEL: if (vs != vt) npc = taken;
            OP_BLEZ: if (vs[63] || vs == '0) npc = taken;
            OP_BGTZ: if (!vs[63] && vs != '0) npc = taken;
            OP_J: npc = jt;
            OP_JAL: begin
               npc = jt; lw = 1'b1; li = LINK_REG; lv = pc + LINK_STEP;
            end
            OP_SPECIAL: begin
               if (bfn == FN_JR) begin
                  npc = vs;
               end else if (bfn == FN_JALR) begin
                  npc = vs; lw = 1'b1; li = bd; lv = pc + LINK_STEP;
               end else begin
                  st = ST_UNIMPL;
               end
            end
            default: st = ST_UNIMPL;
         endcase
         if (lw && li == 5'd0) begin
            lw = 1'b0;
            lv = '0;
         end
      end else begin
         npc = pc;
      end

      if (st != ST_DONE) begin
         dw = 1'b0; lw = 1'b0; dv = '0; lv = '0; npc = pc;
      end
      if (!dw) begin
         di = '0; dv = '0;
      end
      if (!lw) begin
         li = '0; lv = '0;
      end
      return make_rsp(dw, di, dv, lw, li, lv, npc, st);
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 64'd1;
         2: return ALL_ONES;
         3: return MIN_NEG;
         4: return MAX_POS;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     r;
      rsp_type     emulated;
      logic [31:0] tw, bw;
      logic [5:0]  op;
      logic [4:0]  dst, bs, bt;
      r.op_rs_value = pick_value();
      r.op_rt_value = pick_value();
      op = OP_CACHE;
      case ($urandom_range(0, 10))
         0, 1, 2: tw = spec_word(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                                 FN_DADDU);
         3, 4: tw = imm_word(OP_DADDIU, 5'($urandom), 5'($urandom), 16'($urandom));
         5: tw = spec_word(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), FN_DSLL32);
         6: tw = spec_word(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), FN_DSRL32);
         7: tw = spec_word(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), FN_DSRA32);
         8: begin
            case ($urandom_range(0, 9))
               0: op = OP_CACHE;
               1: op = OP_COP0;
               2: op = OP_LD;
               3: op = OP_LDL;
               4: op = OP_LDR;
               5: op = OP_LLD;
               6: op = OP_SD;
               7: op = OP_SDL;
               8: op = OP_SDR;
               default: op = OP_SCD;
            endcase
            tw = {op, 26'($urandom)};
         end
         9: tw = {OP_SPECIAL, 20'($urandom), 6'($urandom)};
         default: tw = $urandom;
      endcase
      dst = (tw[31:26] == OP_DADDIU) ? tw[20:16] : tw[15:11];
      bs = ($urandom_range(0, 1) == 0) ? dst : 5'($urandom);
      bt = ($urandom_range(0, 2) == 0) ? dst : 5'($urandom);
      case ($urandom_range(0, 13))
         0, 1: bw = imm_word(OP_BEQ, bs, bt, 16'($urandom));
         2, 3: bw = imm_word(OP_BNE, bs, bt, 16'($urandom));
         4: bw = imm_word(OP_BNEL, bs, bt, 16'($urandom));
         5: bw = imm_word(OP_BLEZ, bs, bt, 16'($urandom));
         6: bw = imm_word(OP_BGTZ, bs, bt, 16'($urandom));
         7: bw = {OP_J, 26'($urandom)};
         8: bw = {OP_JAL, 26'($urandom)};
         9: bw = spec_word(bs, bt, 5'($urandom), 5'($urandom), FN_JR);
         10: bw = spec_word(bs, bt, ($urandom_range(0, 2) == 0) ? bs : 5'($urandom),
                            5'($urandom), FN_JALR);
         11: bw = imm_word(OP_BCOND, bs, bt, 16'($urandom));
         default: bw = $urandom;
      endcase
      r.trapped_word    = tw;
      r.branch_word     = bw;
      r.in_delay_slot   = ($urandom_range(0, 3) != 0);
      r.trap_pc         = {$urandom, $urandom};
      if ($urandom_range(0, 7) != 0)
         r.trap_pc[1:0] = 2'b00;
      r.branch_rs_value = pick_value();
      r.branch_rt_value = ($urandom_range(0, 3) == 0) ? r.branch_rs_value : pick_value();
      if (bs == dst && $urandom_range(0, 2) == 0) begin
         emulated = predict_trap(r);
         r.branch_rt_value = emulated.dest_value;
      end
      return r;
   endfunction

   task automatic add_golden(input req_type r, input rsp_type g);
      trap_case_type c;
      c.req = r;
      c.has_golden = 1'b1;
      c.golden = g;
      directed_cases.push_back(c);
   endtask

   task automatic add_open(input req_type r);
      trap_case_type c;
      c.req = r;
      c.has_golden = 1'b0;
      c.golden = '0;
      directed_cases.push_back(c);
   endtask

   task automatic send_request(input req_type r, input rsp_type predicted);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_trapped_word    <= r.trapped_word;
      req_branch_word     <= r.branch_word;
      req_trap_pc         <= r.trap_pc;
      req_in_delay_slot   <= r.in_delay_slot;
      req_op_rs_value     <= r.op_rs_value;
      req_op_rt_value     <= r.op_rt_value;
      req_branch_rs_value <= r.branch_rs_value;
      req_branch_rt_value <= r.branch_rt_value;
      do
         @(posedge clock);
      while (!req_ready);
      predicted_rsps.push_back(predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_stall_left <= $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type got, want;
      bit      bad;
      if (!reset && rsp_valid && rsp_ready) begin
         got = make_rsp(rsp_dest_write, rsp_dest_index, rsp_dest_value, rsp_link_write,
                        rsp_link_index, rsp_link_value, rsp_next_pc, status_type'(rsp_status));
         if (predicted_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("Unexpected response at %0t: npc=%h status=%0d", $realtime,
                        got.next_pc, got.status);
         end else begin
            want = predicted_rsps.pop_front();
            bad = (got.dest_write !== want.dest_write) || (got.dest_index !== want.dest_index)
               || (got.dest_value !== want.dest_value) || (got.link_write !== want.link_write)
               || (got.link_index !== want.link_index) || (got.link_value !== want.link_value)
               || (got.next_pc !== want.next_pc) || (got.status !== want.status);
            if (bad) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Mismatch at %0t: expected dw=%0d di=%0d dv=%h lw=%0d li=%0d lv=%h",
                           $realtime, want.dest_write, want.dest_index, want.dest_value,
                           want.link_write, want.link_index, want.link_value);
                  $display("   expected npc=%h st=%0d; got dw=%0d di=%0d dv=%h", want.next_pc,
                           want.status, got.dest_write, got.dest_index, got.dest_value);
                  $display("   got lw=%0d li=%0d lv=%h npc=%h st=%0d", got.link_write,
                           got.link_index, got.link_value, got.next_pc, got.status);
               end
            end
         end
      end
   end

   initial begin
      req_type       r;
      trap_case_type c;
      logic [63:0]   jpc;
      jpc = 64'hfedc_ba98_7654_3210;

      // Extremes of the arithmetic, dropped writes, and the status codes.
      add_golden(make_req(spec_word(5'd1, 5'd2, 5'd3, 5'd0, FN_DADDU), '0, BASE_PC, 1'b0,
                          MAX_POS, 64'd1, '0, '0),
                 make_rsp(1'b1, 5'd3, MIN_NEG, 1'b0, '0, '0, BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(imm_word(OP_DADDIU, 5'd1, 5'd5, 16'h8000), '0, BASE_PC, 1'b0,
                          '0, '0, '0, '0),
                 make_rsp(1'b1, 5'd5, 64'hffff_ffff_ffff_8000, 1'b0, '0, '0,
                          BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(imm_word(OP_DADDIU, 5'd1, 5'd6, 16'h7fff), '0, BASE_PC, 1'b0,
                          MAX_POS, '0, '0, '0),
                 make_rsp(1'b1, 5'd6, 64'h8000_0000_0000_7ffe, 1'b0, '0, '0,
                          BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(spec_word(5'd0, 5'd2, 5'd7, 5'd31, FN_DSLL32), '0, BASE_PC, 1'b0,
                          '0, 64'd1, '0, '0),
                 make_rsp(1'b1, 5'd7, MIN_NEG, 1'b0, '0, '0, BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(spec_word(5'd0, 5'd2, 5'd8, 5'd0, FN_DSRL32), '0, BASE_PC, 1'b0,
                          '0, ALL_ONES, '0, '0),
                 make_rsp(1'b1, 5'd8, 64'h0000_0000_ffff_ffff, 1'b0, '0, '0,
                          BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(spec_word(5'd0, 5'd2, 5'd9, 5'd31, FN_DSRA32), '0, BASE_PC, 1'b0,
                          '0, MIN_NEG, '0, '0),
                 make_rsp(1'b1, 5'd9, ALL_ONES, 1'b0, '0, '0, BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req(spec_word(5'd1, 5'd2, 5'd0, 5'd0, FN_DADDU), '0, BASE_PC, 1'b0,
                          64'd5, 64'd6, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req({OP_CACHE, 26'h3ff_ffff}, '0, BASE_PC, 1'b0, ALL_ONES, ALL_ONES,
                          '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC + 64'd4, ST_DONE));
      add_golden(make_req({OP_COP0, 26'h0}, imm_word(OP_BEQ, 5'd0, 5'd0, 16'h0010), BASE_PC,
                          1'b1, '0, '0, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC, ST_NOT_HANDLED));
      add_golden(make_req({OP_LD, 26'h3ff_ffff}, '0, BASE_PC, 1'b0, '0, '0, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC, ST_NOT_HANDLED));
      add_golden(make_req(spec_word(5'd1, 5'd2, 5'd3, 5'd0, FN_UNUSED), '0, BASE_PC, 1'b0,
                          64'd1, 64'd1, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC, ST_UNIMPL));
      add_golden(make_req(imm_word(OP_UNUSED, 5'd1, 5'd2, 16'h1234), '0, BASE_PC, 1'b0,
                          64'd1, '0, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC, ST_UNIMPL));
      add_golden(make_req(imm_word(OP_DADDIU, 5'd0, 5'd1, 16'h0001), '0,
                          64'hffff_ffff_ffff_fffc, 1'b0, '0, '0, '0, '0),
                 make_rsp(1'b1, 5'd1, 64'd1, 1'b0, '0, '0, '0, ST_DONE));
      add_golden(make_req(imm_word(OP_UNUSED, 5'd1, 5'd2, 16'h0), {OP_J, 26'h3ff_ffff},
                          BASE_PC, 1'b1, '0, '0, '0, '0),
                 make_rsp(1'b0, '0, '0, 1'b0, '0, '0, BASE_PC, ST_UNIMPL));

      // Branches in a delay slot, with and without forwarding of the emulated result.
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BEQ, 5'd4, 5'd5, 16'h0010), BASE_PC, 1'b1,
                        64'd10, 64'd20, '0, 64'd30));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BEQ, 5'd4, 5'd5, 16'h0010), BASE_PC, 1'b1,
                        64'd10, 64'd20, 64'd30, 64'd31));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BNE, 5'd4, 5'd5, 16'h8000), BASE_PC, 1'b1,
                        64'd1, 64'd2, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BNEL, 5'd6, 5'd7, 16'h0040), BASE_PC, 1'b1,
                        64'd1, 64'd2, 64'd5, 64'd5));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BLEZ, 5'd8, 5'd0, 16'h7fff), BASE_PC, 1'b1,
                        64'd1, 64'd2, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BLEZ, 5'd8, 5'd0, 16'hfffe), BASE_PC, 1'b1,
                        64'd1, 64'd2, MIN_NEG, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        imm_word(OP_BGTZ, 5'd4, 5'd0, 16'h0020), BASE_PC, 1'b1,
                        MAX_POS, '0, MIN_NEG, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU), {OP_J, 26'h3ff_ffff},
                        jpc, 1'b1, 64'd1, 64'd2, '0, '0));
      add_open(make_req(imm_word(OP_DADDIU, 5'd1, 5'd31, 16'h0004), {OP_JAL, 26'h000_0001},
                        jpc, 1'b1, 64'd100, '0, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        spec_word(5'd4, 5'd0, 5'd0, 5'd0, FN_JR), BASE_PC, 1'b1,
                        64'h1000, 64'h0234, ALL_ONES, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd4, 5'd0, FN_DADDU),
                        spec_word(5'd4, 5'd0, 5'd4, 5'd0, FN_JALR), BASE_PC, 1'b1,
                        64'h2000, 64'h0010, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd3, 5'd0, FN_DADDU),
                        spec_word(5'd9, 5'd0, 5'd0, 5'd0, FN_JALR), BASE_PC, 1'b1,
                        64'd1, 64'd1, 64'h4000, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd3, 5'd0, FN_DADDU),
                        imm_word(OP_BCOND, 5'd3, 5'd1, 16'h0010), BASE_PC, 1'b1,
                        64'd1, 64'd1, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd3, 5'd0, FN_DADDU),
                        spec_word(5'd3, 5'd0, 5'd0, 5'd0, FN_UNUSED), BASE_PC, 1'b1,
                        64'd1, 64'd1, '0, '0));
      add_open(make_req(spec_word(5'd1, 5'd2, 5'd0, 5'd0, FN_DADDU),
                        imm_word(OP_BEQ, 5'd0, 5'd5, 16'h0100), BASE_PC, 1'b1,
                        64'd1, 64'd1, 64'd7, 64'd7));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_enable <= 1'b1;

      foreach (directed_cases[k]) begin
         c = directed_cases[k];
         send_request(c.req, c.has_golden ? c.golden : predict_trap(c.req));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_enable <= (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 4 != 3);
         r = random_request();
         send_request(r, predict_trap(r));
      end
      req_valid <= 1'b0;

      while (predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0 && predicted_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
